// File: sv/sensor_array_gas_event_sequencer_core_assert.svh
// Assertion macros shared by the checker of the gas event sequencer.
// Both expect signals named clk and rst in the scope of use.
`ifndef SENSOR_ARRAY_GAS_EVENT_SEQUENCER_CORE_ASSERT_SVH
`define SENSOR_ARRAY_GAS_EVENT_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAGS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sags_pkg.sv
package sags_pkg;

  localparam int THR_W      = 16;
  localparam int CONSEC_W   = 8;
  localparam int NEED_W     = 4;
  localparam int WARM_W     = 8;
  localparam int LIMIT_W    = 16;
  localparam int VOTE_W     = 4;
  localparam int PHASE_W    = 3;
  localparam int INDEX_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THR_BASELINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_GAS_IN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_REACTION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONSEC_NEEDED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSORS_NEEDED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_FRAMES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PURGE_LIMIT    = 3'd7;

  // Phase codes as they appear on the result.
  localparam logic [PHASE_W-1:0] PH_CODE_WAIT_BASE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CODE_BASE_STABLE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CODE_GAS_IN      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CODE_REACTION    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CODE_WAIT_SWITCH = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CODE_PURGE       = 3'd5;

  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

  typedef enum logic [5:0] {
    PH_WAIT_BASE   = 6'b000001,
    PH_BASE_STABLE = 6'b000010,
    PH_GAS_IN      = 6'b000100,
    PH_REACTION    = 6'b001000,
    PH_WAIT_SWITCH = 6'b010000,
    PH_PURGE       = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0]    thr_baseline;
    logic [THR_W-1:0]    thr_gas_in;
    logic [THR_W-1:0]    thr_reaction;
    logic [CONSEC_W-1:0] consec_needed;
    logic [NEED_W-1:0]   sensors_needed;
    logic [WARM_W-1:0]   warmup_frames;
    logic [LIMIT_W-1:0]  react_hold;
    logic [LIMIT_W-1:0]  purge_hold;
  } cfg_t;

  // Frame-end event handed from the datapath to the sequencer.
  typedef struct packed {
    logic              valid;
    logic              judged;
    logic [VOTE_W-1:0] votes;
    logic              sys_valve_open;
    logic              alarm_active;
    logic              classify_done;
  } frame_end_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               valve_request;
    logic               features_ready;
    logic [VOTE_W-1:0]  vote_total;
  } result_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_t p);
    logic [PHASE_W-1:0] code;
    unique case (p)
      PH_WAIT_BASE:   code = PH_CODE_WAIT_BASE;
      PH_BASE_STABLE: code = PH_CODE_BASE_STABLE;
      PH_GAS_IN:      code = PH_CODE_GAS_IN;
      PH_REACTION:    code = PH_CODE_REACTION;
      PH_WAIT_SWITCH: code = PH_CODE_WAIT_SWITCH;
      PH_PURGE:       code = PH_CODE_PURGE;
      default:        code = PH_CODE_WAIT_BASE;
    endcase
    return code;
  endfunction

endpackage

// File: sv/sensor_array_gas_event_sequencer_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sensor_index, resistance, last_of_frame,
//                                           sys_valve_open, alarm_active, classify_done
// output    out        out_valid/out_stall  phase, valve_request, features_ready, vote_total
// config    in         cfg_we               cfg_index, cfg_data
//
// Within a frame one reading is taken every cycle unless the output queue
// is full. After a reading marked last_of_frame the input stalls while the
// frame's phase decision settles, until that reading has passed the read,
// rate check and update stages: the threshold and vote bank of the next
// reading depend on the phase decided by the frame's end.
// Reset is synchronous; it clears all control state and the valid bits of
// both memories, so no clearing pass follows it.
// Results wait in a two-entry output queue; beside the frame-end hold-off,
// the input stalls only when both entries are occupied, and during reset.
module sensor_array_gas_event_sequencer_core #(
  parameter int NUM_SENSORS = 14,
  parameter int SAMPLE_BITS = 24,
  parameter int RUN_BITS    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sags_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sags_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sags_pkg::INDEX_W-1:0]    sensor_index,
  input  logic [SAMPLE_BITS-1:0]          resistance,
  input  logic                            last_of_frame,
  input  logic                            sys_valve_open,
  input  logic                            alarm_active,
  input  logic                            classify_done,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sags_pkg::PHASE_W-1:0]    phase,
  output logic                            valve_request,
  output logic                            features_ready,
  output logic [sags_pkg::VOTE_W-1:0]     vote_total
);

  localparam int IDX_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SLOTS   = 3 * NUM_SENSORS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ENTRY_W = RUN_BITS + 1;
  localparam int CMP_W   = (RUN_BITS > sags_pkg::CONSEC_W) ? RUN_BITS : sags_pkg::CONSEC_W;

  // ------------------------------------------------------------------
  // Config registers, written by the user only while the block is idle; unchecked.
  // ------------------------------------------------------------------
  sags_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_baseline   <= '0;
      cfg.thr_gas_in     <= '0;
      cfg.thr_reaction   <= '0;
      cfg.consec_needed  <= sags_pkg::CONSEC_W'(3);
      cfg.sensors_needed <= sags_pkg::NEED_W'(7);
      cfg.warmup_frames  <= sags_pkg::WARM_W'(10);
      cfg.react_hold     <= sags_pkg::LIMIT_W'(60);
      cfg.purge_hold     <= sags_pkg::LIMIT_W'(60);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sags_pkg::REG_THR_BASELINE:   cfg.thr_baseline   <= cfg_data[sags_pkg::THR_W-1:0];
        sags_pkg::REG_THR_GAS_IN:     cfg.thr_gas_in     <= cfg_data[sags_pkg::THR_W-1:0];
        sags_pkg::REG_THR_REACTION:   cfg.thr_reaction   <= cfg_data[sags_pkg::THR_W-1:0];
        sags_pkg::REG_CONSEC_NEEDED:  cfg.consec_needed  <= cfg_data[sags_pkg::CONSEC_W-1:0];
        sags_pkg::REG_SENSORS_NEEDED: cfg.sensors_needed <= cfg_data[sags_pkg::NEED_W-1:0];
        sags_pkg::REG_WARMUP_FRAMES:  cfg.warmup_frames  <= cfg_data[sags_pkg::WARM_W-1:0];
        sags_pkg::REG_STABLE_LIMIT:   cfg.react_hold     <= cfg_data[sags_pkg::LIMIT_W-1:0];
        sags_pkg::REG_PURGE_LIMIT:    cfg.purge_hold     <= cfg_data[sags_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: accept a transaction and launch the memory reads.
  // ------------------------------------------------------------------
  sags_pkg::phase_t           cur_phase;
  sags_pkg::frame_end_t       fe;
  sags_pkg::result_t          fe_result;

  logic                       accept;
  logic                       s0_in_range;
  logic [IDX_W-1:0]           s0_idx;
  logic                       s0_judged;
  logic                       s0_dir;
  logic [sags_pkg::THR_W-1:0] s0_thr;
  logic [SLOT_W-1:0]          s0_base;
  logic [SLOT_W-1:0]          s0_slot;
  logic                       s0_prev_vld;
  logic                       s0_run_vld;

  logic [NUM_SENSORS-1:0]     prev_vld;
  logic [SLOTS-1:0]           run_vld;
  logic [SAMPLE_BITS-1:0]     prev_rdata;
  logic                       prev_we;

  logic [ENTRY_W-1:0]         run_rdata;
  logic                       run_we;
  logic [SLOT_W-1:0]          run_waddr;
  logic [ENTRY_W-1:0]         run_wdata;

  logic                       head_full, skid_full;
  logic                       s1_valid, s2_valid;
  logic                       s1_last, s2_last;

  // While a frame-end transaction is in flight the phase may still change,
  // so the next reading waits until the sequencer has taken its decision.
  assign in_stall = rst || (s1_valid && s1_last) || (s2_valid && s2_last)
                    || (head_full && skid_full);
  assign accept   = in_valid && !in_stall;

  assign s0_in_range = (int'(sensor_index) < NUM_SENSORS);
  assign s0_idx      = IDX_W'(sensor_index);

  always_comb begin
    s0_judged = 1'b1;
    s0_dir    = 1'b0;
    s0_thr    = cfg.thr_baseline;
    s0_base   = '0;
    unique case (cur_phase)
      sags_pkg::PH_WAIT_BASE: begin
        s0_thr = cfg.thr_baseline;
      end
      sags_pkg::PH_BASE_STABLE: begin
        s0_thr  = cfg.thr_gas_in;
        s0_dir  = 1'b1;
        s0_base = SLOT_W'(NUM_SENSORS);
      end
      sags_pkg::PH_GAS_IN: begin
        s0_thr  = cfg.thr_reaction;
        s0_base = SLOT_W'(2 * NUM_SENSORS);
      end
      default: begin
        s0_judged = 1'b0;
      end
    endcase
  end

  assign s0_slot     = s0_base + SLOT_W'(s0_idx);
  assign s0_prev_vld = s0_in_range && prev_vld[s0_idx];
  assign s0_run_vld  = s0_in_range && run_vld[s0_slot];

  // The previous reading is replaced in the same cycle it is read; the
  // read-first memory still returns the old value for this transaction.
  assign prev_we = accept && s0_in_range;

  sags_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NUM_SENSORS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (s0_idx),
    .wdata (resistance),
    .raddr (s0_idx),
    .rdata (prev_rdata)
  );

  // Run counters and vote bits, one bank of NUM_SENSORS entries for each of
  // the three judging phases. An entry is {vote, run}.
  sags_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .raddr (s0_slot),
    .rdata (run_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vld <= '0;
      run_vld  <= '0;
    end else begin
      if (prev_we) begin
        prev_vld[s0_idx] <= 1'b1;
      end
      if (run_we) begin
        run_vld[run_waddr] <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: memory data arrives; the rate product is formed and the
  // run entry is forwarded from writes the read could not see.
  // ------------------------------------------------------------------
  logic                       s1_in_range, s1_judged, s1_dir;
  logic [sags_pkg::THR_W-1:0] s1_thr;
  logic [SLOT_W-1:0]          s1_slot;
  logic [SAMPLE_BITS-1:0]     s1_cur;
  logic                       s1_prev_vld, s1_run_vld;
  logic                       s1_sys_valve, s1_alarm, s1_cls_done;
  logic [SAMPLE_BITS-1:0]     s1_prev;
  logic [ENTRY_W-1:0]         s1_entry;

  logic                       wq_valid;
  logic [SLOT_W-1:0]          wq_slot;
  logic [ENTRY_W-1:0]         wq_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wq_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      wq_valid <= run_we;
    end
  end

  always_ff @(posedge clk) begin
    s1_last      <= last_of_frame;
    s1_in_range  <= s0_in_range;
    s1_judged    <= s0_judged;
    s1_dir       <= s0_dir;
    s1_thr       <= s0_thr;
    s1_slot      <= s0_slot;
    s1_cur       <= resistance;
    s1_prev_vld  <= s0_prev_vld;
    s1_run_vld   <= s0_run_vld;
    s1_sys_valve <= sys_valve_open;
    s1_alarm     <= alarm_active;
    s1_cls_done  <= classify_done;
    wq_slot      <= run_waddr;
    wq_entry     <= run_wdata;
  end

  // A sensor never written reads as zero.
  assign s1_prev = s1_prev_vld ? prev_rdata : '0;

  // The write landing this cycle is newest; next comes the write that
  // landed on the same edge as this transaction's read.
  always_comb begin
    if (run_we && (run_waddr == s1_slot)) begin
      s1_entry = run_wdata;
    end else if (wq_valid && (wq_slot == s1_slot)) begin
      s1_entry = wq_entry;
    end else if (s1_run_vld) begin
      s1_entry = run_rdata;
    end else begin
      s1_entry = '0;
    end
  end

  logic qualify;

  sags_rate #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rate (
    .clk     (clk),
    .cur     (s1_cur),
    .prev    (s1_prev),
    .thr     (s1_thr),
    .dir_ge  (s1_dir),
    .qualify (qualify)
  );

  // ------------------------------------------------------------------
  // Stage 2: run counter and vote update, write-back, frame vote sum.
  // ------------------------------------------------------------------
  logic                        s2_in_range, s2_judged;
  logic [SLOT_W-1:0]           s2_slot;
  logic [RUN_BITS-1:0]         s2_run_old;
  logic                        s2_vote_old;
  logic                        s2_sys_valve, s2_alarm, s2_cls_done;
  logic [RUN_BITS-1:0]         run_inc, run_new;
  logic                        vote_new;
  logic [sags_pkg::VOTE_W-1:0] frame_votes, votes_sum;

  always_ff @(posedge clk) begin
    s2_last      <= s1_last;
    s2_in_range  <= s1_in_range;
    s2_judged    <= s1_judged;
    s2_slot      <= s1_slot;
    s2_run_old   <= s1_entry[RUN_BITS-1:0];
    s2_vote_old  <= s1_entry[RUN_BITS];
    s2_sys_valve <= s1_sys_valve;
    s2_alarm     <= s1_alarm;
    s2_cls_done  <= s1_cls_done;
  end

  assign run_inc  = (s2_run_old == {RUN_BITS{1'b1}}) ? s2_run_old : (s2_run_old + 1'b1);
  assign run_new  = qualify ? run_inc : '0;
  // A failing reading drops the vote; reaching the run target raises it.
  assign vote_new = (qualify && s2_vote_old)
                    || (CMP_W'(run_new) >= CMP_W'(cfg.consec_needed));

  assign run_we    = s2_valid && s2_in_range && s2_judged;
  assign run_waddr = s2_slot;
  assign run_wdata = {vote_new, run_new};

  assign votes_sum = (run_we && vote_new && (frame_votes != sags_pkg::VOTE_MAX))
                     ? (frame_votes + 1'b1) : frame_votes;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_votes <= '0;
    end else if (s2_valid) begin
      frame_votes <= s2_last ? '0 : votes_sum;
    end
  end

  assign fe.valid          = s2_valid && s2_last;
  assign fe.judged         = s2_judged;
  assign fe.votes          = votes_sum;
  assign fe.sys_valve_open = s2_sys_valve;
  assign fe.alarm_active   = s2_alarm;
  assign fe.classify_done  = s2_cls_done;

  sags_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ev     (fe),
    .phase  (cur_phase),
    .result (fe_result)
  );

  // ------------------------------------------------------------------
  // Output queue: a head register that drives the port and a skid entry.
  // ------------------------------------------------------------------
  sags_pkg::result_t head, skid;
  logic              pop;

  assign pop = head_full && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_full <= 1'b0;
      skid_full <= 1'b0;
      head      <= '0;
      skid      <= '0;
    end else if (pop) begin
      if (skid_full) begin
        head <= skid;
        if (fe.valid) begin
          skid <= fe_result;
        end else begin
          skid_full <= 1'b0;
        end
      end else begin
        head_full <= fe.valid;
        if (fe.valid) begin
          head <= fe_result;
        end
      end
    end else if (fe.valid) begin
      if (!head_full) begin
        head      <= fe_result;
        head_full <= 1'b1;
      end else begin
        skid      <= fe_result;
        skid_full <= 1'b1;
      end
    end
  end

  assign out_valid      = head_full;
  assign phase          = head.phase;
  assign valve_request  = head.valve_request;
  assign features_ready = head.features_ready;
  assign vote_total     = head.vote_total;

endmodule

// File: sv/sags_ram.sv
module sags_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same address in one cycle
  // return the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sags_rate.sv
module sags_rate #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                       clk,
  input  logic [SAMPLE_BITS-1:0]     cur,
  input  logic [SAMPLE_BITS-1:0]     prev,
  input  logic [sags_pkg::THR_W-1:0] thr,
  input  logic                       dir_ge,
  output logic                       qualify
);

  localparam int PROD_W = SAMPLE_BITS + sags_pkg::THR_W;

  logic [SAMPLE_BITS-1:0] diff;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      lhs;
  logic [PROD_W-1:0]      rhs;
  logic                   prev_zero;
  logic                   dir_q;

  assign diff = (cur >= prev) ? (cur - prev) : (prev - cur);
  assign prod = thr * prev;

  // |cur - prev| scaled by 2^16 against thr * prev, registered once.
  always_ff @(posedge clk) begin
    lhs       <= {diff, {sags_pkg::THR_W{1'b0}}};
    rhs       <= prod;
    prev_zero <= (prev == '0);
    dir_q     <= dir_ge;
  end

  // A zero previous reading is an unbounded rate.
  assign qualify = prev_zero ? dir_q : (dir_q ? (lhs >= rhs) : (lhs <= rhs));

endmodule

// File: sv/sags_seq.sv
module sags_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  sags_pkg::cfg_t       cfg,
  input  sags_pkg::frame_end_t ev,
  output sags_pkg::phase_t     phase,
  output sags_pkg::result_t    result
);

  sags_pkg::phase_t              phase_next;
  logic [sags_pkg::WARM_W-1:0]   warmup, warmup_next;
  logic [sags_pkg::LIMIT_W-1:0]  stable_cnt, stable_cnt_next;
  logic [sags_pkg::LIMIT_W-1:0]  purge_cnt, purge_cnt_next;
  logic                          valve, valve_next;
  logic                          features, features_next;
  logic                          vote_ok;

  assign vote_ok = (ev.votes >= cfg.sensors_needed);

  always_comb begin
    phase_next      = phase;
    stable_cnt_next = stable_cnt;
    purge_cnt_next  = purge_cnt;
    valve_next      = valve;
    features_next   = features;
    warmup_next     = (warmup < cfg.warmup_frames) ? (warmup + 1'b1) : warmup;
    unique case (phase)
      sags_pkg::PH_WAIT_BASE: begin
        if (vote_ok && (warmup_next >= cfg.warmup_frames)) begin
          phase_next = sags_pkg::PH_BASE_STABLE;
        end
      end
      sags_pkg::PH_BASE_STABLE: begin
        if (vote_ok) begin
          phase_next = sags_pkg::PH_GAS_IN;
        end
      end
      sags_pkg::PH_GAS_IN: begin
        if (vote_ok) begin
          phase_next = sags_pkg::PH_REACTION;
        end
      end
      sags_pkg::PH_REACTION: begin
        if (stable_cnt != '1) begin
          stable_cnt_next = stable_cnt + 1'b1;
        end
        if (stable_cnt_next > cfg.react_hold) begin
          features_next = 1'b1;
          if (ev.classify_done) begin
            phase_next = sags_pkg::PH_WAIT_SWITCH;
          end
        end
      end
      sags_pkg::PH_WAIT_SWITCH: begin
        valve_next = 1'b1;
        if (ev.sys_valve_open && ev.alarm_active) begin
          phase_next = sags_pkg::PH_PURGE;
        end
      end
      sags_pkg::PH_PURGE: begin
        if (purge_cnt != '1) begin
          purge_cnt_next = purge_cnt + 1'b1;
        end
        if (purge_cnt_next >= cfg.purge_hold) begin
          valve_next = 1'b0;
        end
        if (!ev.sys_valve_open) begin
          phase_next = sags_pkg::PH_WAIT_BASE;
        end
      end
      default: begin
        phase_next = sags_pkg::PH_WAIT_BASE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sags_pkg::PH_WAIT_BASE;
      warmup     <= '0;
      stable_cnt <= '0;
      purge_cnt  <= '0;
      valve      <= 1'b0;
      features   <= 1'b0;
    end else if (ev.valid) begin
      phase      <= phase_next;
      warmup     <= warmup_next;
      stable_cnt <= stable_cnt_next;
      purge_cnt  <= purge_cnt_next;
      valve      <= valve_next;
      features   <= features_next;
    end
  end

  assign result.phase          = sags_pkg::phase_code(phase_next);
  assign result.valve_request  = valve_next;
  assign result.features_ready = features_next;
  assign result.vote_total     = ev.judged ? ev.votes : '0;

endmodule

// File: sv/sags_checker.sv
`include "sensor_array_gas_event_sequencer_core_assert.svh"

module sags_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          last_of_frame,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sags_pkg::PHASE_W-1:0]  phase,
  input logic                          features_ready,
  input logic [sags_pkg::VOTE_W-1:0]   vote_total
);

  // A stalled result keeps its contents.
  `SAGS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(phase) && $stable(vote_total), "stalled result changed")

  // The cycle after a frame-end transaction the input must be held off.
  `SAGS_ASSERT_NEXT(a_frame_interlock, in_valid && !in_stall && last_of_frame, in_stall, "input taken during frame-end interlock")

  // Leaving the reaction phase requires the features flag.
  `SAGS_ASSERT_SAME(a_features_before_switch, out_valid && (phase == sags_pkg::PH_CODE_WAIT_SWITCH || phase == sags_pkg::PH_CODE_PURGE), features_ready, "switch or purge without features ready")

  // Features ready is sticky until reset.
  `SAGS_ASSERT_SAME(a_features_sticky, $fell(features_ready), $past(rst), "features ready dropped")

  // Votes only come from judging phases, which lead at most to reaction.
  `SAGS_ASSERT_SAME(a_votes_phase, out_valid && vote_total != '0, phase == sags_pkg::PH_CODE_WAIT_BASE || phase == sags_pkg::PH_CODE_BASE_STABLE || phase == sags_pkg::PH_CODE_GAS_IN || phase == sags_pkg::PH_CODE_REACTION, "votes reported outside a judging frame")

endmodule

bind sensor_array_gas_event_sequencer_core sags_checker u_sags_checker (.*);

// File: tb/sensor_array_gas_event_sequencer_core_test.sv
module sensor_array_gas_event_sequencer_core_test;

  import sags_pkg::*;

  localparam int NUM_SENSORS = 14;
  localparam int SAMPLE_BITS = 24;

  // Keeps its own copy of the sequencer state and settings. Each accepted
  // input transaction advances that copy, and every frame end leaves one
  // expected report behind for the output side to compare against.
  class sequencer_scoreboard;
    logic [15:0] thresholds[3];
    logic [7:0]  consec_needed;
    logic [3:0]  sensors_needed;
    logic [7:0]  warmup_frames;
    logic [15:0] react_hold;
    logic [15:0] purge_hold;

    logic [SAMPLE_BITS-1:0] last_reading[NUM_SENSORS];
    logic [7:0]  run_len[3][NUM_SENSORS];
    logic        voted[3][NUM_SENSORS];
    logic [3:0]  votes_acc;
    logic [2:0]  phase_now;
    logic [7:0]  warm_count;
    logic [15:0] stable_count;
    logic [15:0] purge_count;
    logic        valve_on;
    logic        features_on;

    result_t expected_reports[$];
    int      mismatch_count;

    function new();
      thresholds = '{default: '0};
      consec_needed = 8'd3;
      sensors_needed = 4'd7;
      warmup_frames = 8'd10;
      react_hold = 16'd60;
      purge_hold = 16'd60;
      foreach (last_reading[i]) last_reading[i] = '0;
      foreach (run_len[b, i]) begin
        run_len[b][i] = '0;
        voted[b][i] = 1'b0;
      end
      votes_acc = '0;
      phase_now = PH_CODE_WAIT_BASE;
      warm_count = '0;
      stable_count = '0;
      purge_count = '0;
      valve_on = 1'b0;
      features_on = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THR_BASELINE:   thresholds[0] = data;
        REG_THR_GAS_IN:     thresholds[1] = data;
        REG_THR_REACTION:   thresholds[2] = data;
        REG_CONSEC_NEEDED:  consec_needed = data[7:0];
        REG_SENSORS_NEEDED: sensors_needed = data[3:0];
        REG_WARMUP_FRAMES:  warmup_frames = data[7:0];
        REG_STABLE_LIMIT:   react_hold = data;
        default:            purge_hold = data;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 100) $display("MISMATCH %0d: %s", mismatch_count, msg);
    endtask

    function void note_reading(logic [3:0] idx, logic [SAMPLE_BITS-1:0] cur, logic last,
                               logic valve_open, logic alarm, logic cls_done);
      logic [2:0]             start;
      logic [SAMPLE_BITS-1:0] prior;
      logic [SAMPLE_BITS-1:0] diff;
      logic [39:0]            scaled_diff;
      logic [39:0]            scaled_thr;
      logic [3:0]             votes;
      logic                   hit;
      int                     bank;
      result_t                rpt;

      start = phase_now;
      if (idx < NUM_SENSORS) begin
        prior = last_reading[idx];
        // Only the three judging phases touch the run counters, each its own bank.
        if (start <= PH_CODE_GAS_IN) begin
          bank = int'(start);
          diff = (cur >= prior) ? cur - prior : prior - cur;
          scaled_diff = {diff, 16'h0000};
          scaled_thr = 40'(thresholds[bank]) * 40'(prior);
          // A zero previous reading is an unbounded change: never calm, always a jump.
          if (prior == '0) hit = (start == PH_CODE_BASE_STABLE);
          else if (start == PH_CODE_BASE_STABLE) hit = (scaled_diff >= scaled_thr);
          else hit = (scaled_diff <= scaled_thr);
          if (hit) begin
            if (run_len[bank][idx] != '1) run_len[bank][idx]++;
          end else begin
            run_len[bank][idx] = '0;
            voted[bank][idx] = 1'b0;
          end
          if (run_len[bank][idx] >= consec_needed) voted[bank][idx] = 1'b1;
          if (voted[bank][idx] && votes_acc != '1) votes_acc++;
        end
        last_reading[idx] = cur;
      end
      if (!last) return;

      votes = votes_acc;
      votes_acc = '0;
      if (warm_count < warmup_frames) warm_count++;
      case (start)
        PH_CODE_WAIT_BASE: begin
          if (votes >= sensors_needed && warm_count >= warmup_frames)
            phase_now = PH_CODE_BASE_STABLE;
        end
        PH_CODE_BASE_STABLE: begin
          if (votes >= sensors_needed) phase_now = PH_CODE_GAS_IN;
        end
        PH_CODE_GAS_IN: begin
          if (votes >= sensors_needed) phase_now = PH_CODE_REACTION;
        end
        PH_CODE_REACTION: begin
          if (stable_count != '1) stable_count++;
          if (stable_count > react_hold) begin
            features_on = 1'b1;
            if (cls_done) phase_now = PH_CODE_WAIT_SWITCH;
          end
        end
        PH_CODE_WAIT_SWITCH: begin
          valve_on = 1'b1;
          if (valve_open && alarm) phase_now = PH_CODE_PURGE;
        end
        default: begin
          if (purge_count != '1) purge_count++;
          if (purge_count >= purge_hold) valve_on = 1'b0;
          if (!valve_open) phase_now = PH_CODE_WAIT_BASE;
        end
      endcase

      rpt.phase = phase_now;
      rpt.valve_request = valve_on;
      rpt.features_ready = features_on;
      rpt.vote_total = (start <= PH_CODE_GAS_IN) ? votes : '0;
      expected_reports.push_back(rpt);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("report with none pending: phase %0d votes %0d",
                                  got.phase, got.vote_total));
        return;
      end
      want = expected_reports.pop_front();
      if (got.phase !== want.phase)
        report_mismatch($sformatf("phase %0d, wanted %0d", got.phase, want.phase));
      if (got.valve_request !== want.valve_request)
        report_mismatch($sformatf("valve_request %b, wanted %b",
                                  got.valve_request, want.valve_request));
      if (got.features_ready !== want.features_ready)
        report_mismatch($sformatf("features_ready %b, wanted %b",
                                  got.features_ready, want.features_ready));
      if (got.vote_total !== want.vote_total)
        report_mismatch($sformatf("vote_total %0d, wanted %0d",
                                  got.vote_total, want.vote_total));
    endtask
  endclass

  // Every input of the block starts at a known value; reset is held from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [INDEX_W-1:0]     sensor_index = '0;
  logic [SAMPLE_BITS-1:0] resistance = '0;
  logic                   last_of_frame = 1'b0;
  logic                   sys_valve_open = 1'b0;
  logic                   alarm_active = 1'b0;
  logic                   classify_done = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PHASE_W-1:0]     phase;
  logic                   valve_request;
  logic                   features_ready;
  logic [VOTE_W-1:0]      vote_total;

  sequencer_scoreboard board = new();

  // Input transactions that the block can act on: an in-range reading or a frame end.
  int items_taken = 0;
  // The sender runs without gaps while this is set.
  bit tx_calm = 1'b0;
  // Each bump asks the receiver for one long hold-off so that the block backs up.
  int backlog_requests = 0;
  int backlog_served = 0;
  int hold_left = 0;
  int rx_wait = 0;
  bit rx_calm = 1'b0;

  sensor_array_gas_event_sequencer_core #(
    .NUM_SENSORS(NUM_SENSORS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .RUN_BITS(8)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sensor_index(sensor_index),
    .resistance(resistance),
    .last_of_frame(last_of_frame),
    .sys_valve_open(sys_valve_open),
    .alarm_active(alarm_active),
    .classify_done(classify_done),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .phase(phase),
    .valve_request(valve_request),
    .features_ready(features_ready),
    .vote_total(vote_total)
  );

  always #4 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Settings lean toward values that let the phases move, with both extremes mixed in.
  function automatic int unsigned pick_setting(int unsigned top, int unsigned usual);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return top;
    return $urandom_range(0, usual);
  endfunction

  // Builds the next reading of a sensor from its previous one. A calm reading stays
  // within the threshold, a jump goes past it; a third of them land right on the edge
  // of the cross-multiplied comparison.
  function automatic logic [SAMPLE_BITS-1:0] make_reading(logic [SAMPLE_BITS-1:0] prior,
                                                           logic [15:0] thr, bit calm);
    int unsigned bound;
    int unsigned diff;
    if (prior == '0 || $urandom_range(0, 24) == 0)
      return ($urandom_range(0, 9) == 0) ? '0 : SAMPLE_BITS'($urandom);
    bound = 32'((40'(thr) * 40'(prior)) >> 16);
    case ($urandom_range(0, 2))
      0: diff = calm ? bound : bound + 1;
      1: diff = calm ? 0 : 32'(prior);
      default: diff = calm ? $urandom_range(0, bound) : bound + 1 + $urandom_range(0, prior);
    endcase
    if ($urandom_range(0, 1) == 1 && 32'(prior) + diff <= 32'hFF_FFFF)
      return SAMPLE_BITS'(32'(prior) + diff);
    if (diff <= 32'(prior)) return SAMPLE_BITS'(32'(prior) - diff);
    return '1;
  endfunction

  // Configuration writes happen only while the block is idle. Bits above a
  // narrow register's width carry random junk, which the block must ignore.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    case (idx)
      REG_CONSEC_NEEDED, REG_WARMUP_FRAMES: mask = 16'h00FF;
      REG_SENSORS_NEEDED:                   mask = 16'h000F;
      default:                              mask = 16'hFFFF;
    endcase
    data = (16'($urandom) & ~mask) | (16'(val) & mask);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned thr_base, input int unsigned thr_gas,
                                input int unsigned thr_react, input int unsigned consec,
                                input int unsigned needed, input int unsigned warmup,
                                input int unsigned stable_lim, input int unsigned purge_lim);
    write_reg(REG_THR_BASELINE, thr_base);
    write_reg(REG_THR_GAS_IN, thr_gas);
    write_reg(REG_THR_REACTION, thr_react);
    write_reg(REG_CONSEC_NEEDED, consec);
    write_reg(REG_SENSORS_NEEDED, needed);
    write_reg(REG_WARMUP_FRAMES, warmup);
    write_reg(REG_STABLE_LIMIT, stable_lim);
    write_reg(REG_PURGE_LIMIT, purge_lim);
    cfg_we <= 1'b0;
  endtask

  // Offers one input transaction, after an optional idle gap, and holds it until
  // the block takes it. Valid is only ever raised here and only lowered by a gap
  // or by the drain before a configuration change, never both in one step.
  task automatic offer_reading(input logic [3:0] idx, input logic [SAMPLE_BITS-1:0] res,
                               input bit last, input bit valve_open, input bit alarm,
                               input bit cls_done);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_index <= idx;
    resistance <= res;
    last_of_frame <= last;
    sys_valve_open <= valve_open;
    alarm_active <= alarm;
    classify_done <= cls_done;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_reading(idx, res, last, valve_open, alarm, cls_done);
    if (idx < NUM_SENSORS || last) items_taken++;
  endtask

  // A frame shaped to push the current phase forward. Most frames walk all
  // sensors in order; others are short, carry repeated sensors (enough to
  // saturate the vote sum), or have stray out-of-range indexes mixed in.
  task automatic send_frame();
    int                     n;
    int                     shape;
    int                     k;
    logic [3:0]             idx;
    logic [SAMPLE_BITS-1:0] cur;
    logic [15:0]            thr;
    logic [2:0]             ph;
    bit                     calm;
    bit                     valve_open;
    bit                     alarm;
    bit                     cls_done;

    shape = $urandom_range(0, 99);
    if (shape < 70 || shape >= 92) n = NUM_SENSORS;
    else if (shape < 82) n = $urandom_range(1, NUM_SENSORS - 1);
    else n = $urandom_range(NUM_SENSORS + 1, 20);

    for (k = 0; k < n; k++) begin
      if (shape >= 70 && shape < 82) idx = 4'($urandom_range(0, NUM_SENSORS - 1));
      else if (shape >= 92 && $urandom_range(0, 9) == 0)
        idx = 4'($urandom_range(NUM_SENSORS, 15));
      else idx = 4'(k % NUM_SENSORS);

      // The phase only moves at a frame end, so the predicted phase is the live one.
      ph = board.phase_now;
      thr = (ph <= PH_CODE_GAS_IN) ? board.thresholds[int'(ph)] : 16'($urandom);
      calm = (ph != PH_CODE_BASE_STABLE) ^ ($urandom_range(0, 99) < 12);
      cur = (idx < NUM_SENSORS) ? make_reading(board.last_reading[idx], thr, calm)
                                : SAMPLE_BITS'($urandom);

      valve_open = 1'($urandom);
      alarm = 1'($urandom);
      cls_done = 1'($urandom);
      if (ph == PH_CODE_WAIT_SWITCH && $urandom_range(0, 99) < 60) begin
        valve_open = 1'b1;
        alarm = 1'b1;
      end
      if (ph == PH_CODE_PURGE) valve_open = ($urandom_range(0, 99) >= 40);
      offer_reading(idx, cur, k == n - 1, valve_open, alarm, cls_done);
    end
  endtask

  // Unshaped transactions: any index, any reading, frame ends at random.
  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 6);
    repeat (n)
      offer_reading(4'($urandom), SAMPLE_BITS'($urandom), $urandom_range(0, 99) < 25,
                    1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Drops valid, waits for every pending report, then lets the pipeline run dry
  // so that a trailing reading without a frame end is finished too.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (board.expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Output side. A transaction is taken at an edge where out_valid is high and
  // out_stall is low; the stall pattern mixes short gaps, calm stretches and,
  // on request, one long hold-off that fills the output queue and backs up
  // the input.
  always @(posedge clk) begin
    result_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.phase = phase;
      seen.valve_request = valve_request;
      seen.features_ready = features_ready;
      seen.vote_total = vote_total;
      board.check_result(seen);
    end
    if (backlog_served != backlog_requests) begin
      backlog_served = backlog_requests;
      hold_left = 300;
    end
    if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      rx_wait = rx_calm ? 0 : pick_gap();
    end
  end

  initial begin
    int seg;
    int goal;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every phase with single-reading frames. Settings are
    // loose so that one vote advances, purge expires after one frame and the stable period after two.
    apply_settings(16'h8000, 16'h1000, 16'hFFFF, 1, 1, 2, 1, 1);
    // Zero previous readings: the change is unbounded and never counts as calm.
    offer_reading(4'd0, 24'h000000, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_reading(4'd0, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    // Unchanged full-scale reading votes, but warmup is still running.
    offer_reading(4'd0, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    // Out-of-range sensor that still closes a frame.
    offer_reading(4'd15, 24'h123456, 1'b1, 1'b1, 1'b1, 1'b1);
    // Highest sensor, steady reading: baseline becomes stable.
    offer_reading(4'd13, 24'h800000, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_reading(4'd13, 24'h800000, 1'b1, 1'b0, 1'b0, 1'b0);
    // Large drop qualifies as gas in; the frame is closed by an out-of-range index.
    offer_reading(4'd13, 24'h000001, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_reading(4'd14, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    // Steady again: reaction stable.
    offer_reading(4'd13, 24'h000001, 1'b1, 1'b0, 1'b0, 1'b0);
    // Stable period runs out, features become ready and the classifier finishes.
    offer_reading(4'd5, 24'h0ABCDE, 1'b1, 1'b0, 1'b0, 1'b1);
    offer_reading(4'd5, 24'h543210, 1'b1, 1'b0, 1'b0, 1'b1);
    // Waiting for the switch needs both the valve and the alarm.
    offer_reading(4'd0, 24'h00FF00, 1'b1, 1'b1, 1'b0, 1'b0);
    offer_reading(4'd0, 24'h00FF00, 1'b1, 1'b0, 1'b1, 1'b0);
    offer_reading(4'd0, 24'h00FF00, 1'b1, 1'b1, 1'b1, 1'b0);
    // Purge drops the valve request, then returns to baseline once the valve closes.
    offer_reading(4'd9, 24'h3C3C3C, 1'b1, 1'b1, 1'b0, 1'b0);
    offer_reading(4'd9, 24'hC3C3C3, 1'b1, 1'b0, 1'b0, 1'b0);

    // Random segments, each under its own settings, one segment all zeros and
    // one at every maximum.
    for (seg = 0; seg < 8; seg++) begin
      wait_for_quiet();
      case (seg)
        1: apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        4: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 14, 255, 16'hFFFF, 16'hFFFF);
        default: begin
          apply_settings(pick_setting(65535, 65535), pick_setting(65535, 65535),
                         pick_setting(65535, 65535), pick_setting(255, 4),
                         pick_setting(14, 14), pick_setting(255, 8),
                         pick_setting(65535, 8), pick_setting(65535, 8));
        end
      endcase
      if (seg == 2 || seg == 5) backlog_requests++;
      goal = items_taken + 195;
      // Every pass ends with a whole frame, so a segment always closes on a frame end.
      while (items_taken < goal) begin
        if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
        if ($urandom_range(0, 99) < 12) noise_burst();
        send_frame();
      end
    end

    wait_for_quiet();
    if (board.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
